### rtl/nalsc_pkg.sv
// ----------------------------------------------------------------------------
// nalsc_pkg
// Types and constants for the Annex B start code splitter.
// ----------------------------------------------------------------------------
package nalsc_pkg;

    // start code is three zero bytes then this byte
    localparam logic [23:0] START_PREFIX = 24'h000000;
    localparam logic [7:0]  START_LAST   = 8'h01;
    localparam logic [4:0]  TYPE_MASK    = 5'h1f;

    localparam int          SIZE_FIELD_W   = 20;
    localparam logic [19:0] SIZE_FIELD_MAX = 20'hfffff;

    localparam int MAX_RESULTS = 5;

    // result kind codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       buffer_end;
    } in_t;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              payload_byte;
        logic                    first_of_unit;
        logic [4:0]              unit_type;
        logic [SIZE_FIELD_W-1:0] unit_size;
        logic                    run_end;
    } out_t;

endpackage

### rtl/nal_unit_start_code_splitter.sv
// ----------------------------------------------------------------------------
// nal_unit_start_code_splitter
// Splits a byte stream at 00 00 00 01 start codes into payload bytes and
// end-of-unit markers, holding three bytes back in a sliding window.
// ----------------------------------------------------------------------------
// data path: the accepted byte is registered, then its results load the result buffer
// throughput: one byte per cycle while each byte gives at most one result and
//   m_ready stays high; a byte giving up to 5 results holds the buffer until all are taken
// reset: synchronous active-low aresetn clears the window, unit state and
//   both valid flags; held results are dropped
module nal_unit_start_code_splitter
    import nalsc_pkg::*;
#(
    parameter int SIZE_BITS = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int EW = (SIZE_BITS > SIZE_FIELD_W) ? SIZE_BITS : SIZE_FIELD_W;
    localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = '1;

    // input register
    logic in_vld_reg;
    in_t  in_reg;

    // unit state
    logic [23:0]          held_reg,    held_next;
    logic [1:0]           hcnt_reg,    hcnt_next;
    logic                 inside_reg,  inside_next;
    logic                 fpend_reg,   fpend_next;
    logic [4:0]           ctype_reg,   ctype_next;
    logic [SIZE_BITS-1:0] total_reg,   total_next;

    // result buffer
    out_t res_reg [MAX_RESULTS];
    out_t res_next [MAX_RESULTS];
    logic [2:0] rd_idx_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    logic out_free;
    logic load;

    assign out_free = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);
    assign load     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign m_valid  = (cnt_reg != 3'd0);
    assign m_data   = res_reg[rd_idx_reg];

    always_comb begin
        logic                 match;
        logic                 shift_emit;
        logic                 flush;
        logic [23:0]          win;
        logic [1:0]           wcnt;
        logic [23:0]          win_al;
        logic [31:0]          seq;
        logic [2:0]           n;
        logic                 end_mk;
        logic [SIZE_BITS:0]   sum;
        logic [SIZE_BITS-1:0] tot_after;
        logic [EW-1:0]        tot_ext;
        logic [19:0]          rep_size;
        logic [4:0]           type_after;
        logic [4:0]           first_type;

        match      = (hcnt_reg == 2'd3) && (held_reg == START_PREFIX)
                     && (in_reg.stream_byte == START_LAST);
        shift_emit = !match && (hcnt_reg == 2'd3) && inside_reg;
        flush      = in_reg.buffer_end;

        win  = {held_reg[15:0], in_reg.stream_byte};
        wcnt = (hcnt_reg == 2'd3) ? 2'd3 : hcnt_reg + 2'd1;

        // move the oldest held byte to the top of the window
        case (wcnt)
            2'd1:    win_al = {win[7:0], 16'h0000};
            2'd2:    win_al = {win[15:0], 8'h00};
            2'd3:    win_al = win;
            default: win_al = 24'h000000;
        endcase
        seq = shift_emit ? {held_reg[23:16], win_al} : {win_al, 8'h00};

        n = 3'd0;
        if (!match && inside_reg) begin
            n = {2'b00, shift_emit} + (flush ? {1'b0, wcnt} : 3'd0);
        end

        sum       = {1'b0, total_reg} + (SIZE_BITS+1)'(n);
        tot_after = sum[SIZE_BITS] ? SIZE_LIMIT : sum[SIZE_BITS-1:0];
        tot_ext   = EW'(tot_after);
        rep_size  = (tot_ext > EW'(SIZE_FIELD_MAX)) ? SIZE_FIELD_MAX : tot_ext[19:0];

        first_type = seq[28:24] & TYPE_MASK;
        type_after = (fpend_reg && n != 3'd0) ? first_type : ctype_reg;

        end_mk = inside_reg && (tot_after != '0) && (match || flush);

        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_next[k].kind          = (3'(k) < n) ? KIND_PAYLOAD : KIND_END;
            res_next[k].payload_byte  = 8'h00;
            res_next[k].first_of_unit = 1'b0;
            res_next[k].unit_type     = type_after;
            res_next[k].unit_size     = rep_size;
            res_next[k].run_end       = (3'(k) + 3'd1 == n + {2'b00, end_mk});
            if (3'(k) < n) begin
                res_next[k].payload_byte  = seq[31 - 8*(k%4) -: 8];
                res_next[k].first_of_unit = (k == 0) && fpend_reg;
                res_next[k].unit_size     = '0;
            end
        end

        cnt_next = n + {2'b00, end_mk};

        if (match) begin
            held_next   = 24'h000000;
            hcnt_next   = 2'd0;
            inside_next = 1'b1;
            fpend_next  = 1'b1;
            ctype_next  = ctype_reg;
            total_next  = '0;
        end else begin
            held_next   = win;
            hcnt_next   = wcnt;
            inside_next = inside_reg;
            fpend_next  = fpend_reg && (n == 3'd0);
            ctype_next  = type_after;
            total_next  = tot_after;
        end

        // end of buffer returns the window and unit state to reset
        if (flush) begin
            held_next   = 24'h000000;
            hcnt_next   = 2'd0;
            inside_next = 1'b0;
            fpend_next  = 1'b0;
            ctype_next  = 5'd0;
            total_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            held_reg   <= 24'h000000;
            hcnt_reg   <= 2'd0;
            inside_reg <= 1'b0;
            fpend_reg  <= 1'b0;
            ctype_reg  <= 5'd0;
            total_reg  <= '0;
            rd_idx_reg <= 3'd0;
            cnt_reg    <= 3'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (load) begin
                held_reg   <= held_next;
                hcnt_reg   <= hcnt_next;
                inside_reg <= inside_next;
                fpend_reg  <= fpend_next;
                ctype_reg  <= ctype_next;
                total_reg  <= total_next;
                rd_idx_reg <= 3'd0;
                cnt_reg    <= cnt_next;
            end else if (m_valid && m_ready) begin
                rd_idx_reg <= rd_idx_reg + 3'd1;
                cnt_reg    <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (load) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                res_reg[k] <= res_next[k];
            end
        end
    end

endmodule

### tb/nalsc_checker.sv
// ----------------------------------------------------------------------------
// nalsc_checker
// Watches both channels of the start code splitter, keeps its own copy of
// the sliding window and unit state, and compares every result transfer
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module nalsc_checker
    import nalsc_pkg::*;
#(
    parameter int SIZE_BITS = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   err_count,
    output int   outstanding,
    output int   bytes_seen,
    output int   markers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] COUNT_LIMIT_W = (SIZE_BITS >= 32) ? 64'hffff_ffff
                                          : ((64'd1 << SIZE_BITS) - 64'd1);
    localparam logic [31:0] COUNT_LIMIT   = COUNT_LIMIT_W[31:0];

    logic [23:0] win_bytes;
    logic [1:0]  win_count;
    logic        in_unit;
    logic        first_due;
    logic [4:0]  cur_type;
    logic [31:0] unit_bytes;

    out_t unit_results_q[$];

    task automatic clear_state();
        win_bytes  = '0;
        win_count  = '0;
        in_unit    = 1'b0;
        first_due  = 1'b0;
        cur_type   = '0;
        unit_bytes = '0;
    endtask

    task automatic push_payload(input logic [7:0] b);
        out_t r;
        r = '0;
        if (first_due) begin
            cur_type        = b[4:0] & TYPE_MASK;
            first_due       = 1'b0;
            r.first_of_unit = 1'b1;
        end
        if (unit_bytes < COUNT_LIMIT) begin
            unit_bytes++;
        end
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.unit_type    = cur_type;
        unit_results_q = {unit_results_q, r};
    endtask

    task automatic push_end();
        out_t r;
        r           = '0;
        r.kind      = KIND_END;
        r.unit_type = cur_type;
        r.unit_size = (unit_bytes > 32'(SIZE_FIELD_MAX)) ? SIZE_FIELD_MAX
                                                         : unit_bytes[SIZE_FIELD_W-1:0];
        unit_results_q = {unit_results_q, r};
    endtask

    // one accepted stream byte, appends whatever results it causes
    task automatic split_byte(input in_t item);
        int   base;
        int   i;
        int   last_idx;
        out_t tail;
        base = unit_results_q.size();
        if (win_count == 2'd3 && win_bytes == START_PREFIX && item.stream_byte == START_LAST) begin
            if (in_unit && unit_bytes > 0) begin
                push_end();
            end
            in_unit    = 1'b1;
            first_due  = 1'b1;
            unit_bytes = '0;
            win_bytes  = '0;
            win_count  = '0;
        end else if (win_count == 2'd3) begin
            // oldest byte leaves the window, dropped when outside a unit
            if (in_unit) begin
                push_payload(win_bytes[23:16]);
            end
            win_bytes = {win_bytes[15:0], item.stream_byte};
        end else begin
            win_bytes = {win_bytes[15:0], item.stream_byte};
            win_count++;
        end
        if (item.buffer_end) begin
            if (in_unit) begin
                for (i = int'(win_count) - 1; i >= 0; i--) begin
                    push_payload(win_bytes[8*i +: 8]);
                end
                if (unit_bytes > 0) begin
                    push_end();
                end
            end
            clear_state();
        end
        if (unit_results_q.size() > base) begin
            last_idx                 = unit_results_q.size() - 1;
            tail                     = unit_results_q[last_idx];
            tail.run_end             = 1'b1;
            unit_results_q[last_idx] = tail;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            clear_state();
            unit_results_q.delete();
            err_count    = 0;
            bytes_seen   = 0;
            markers_seen = 0;
        end else begin
            if (s_valid && s_ready) begin
                split_byte(s_data);
            end
            if (m_valid && m_ready) begin
                if (unit_results_q.size() == 0) begin
                    $error("unexpected result transfer: kind %0d byte 0x%0h size %0d",
                           m_data.kind, m_data.payload_byte, m_data.unit_size);
                    err_count++;
                end else begin
                    want = unit_results_q[0];
                    unit_results_q.delete(0);
                    check_field("kind", 32'(want.kind), 32'(m_data.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(m_data.payload_byte));
                    check_field("first_of_unit", 32'(want.first_of_unit),
                                32'(m_data.first_of_unit));
                    check_field("unit_type", 32'(want.unit_type), 32'(m_data.unit_type));
                    check_field("unit_size", 32'(want.unit_size), 32'(m_data.unit_size));
                    check_field("run_end", 32'(want.run_end), 32'(m_data.run_end));
                end
                if (m_data.kind == KIND_END) begin
                    markers_seen++;
                end else begin
                    bytes_seen++;
                end
            end
        end
        outstanding = unit_results_q.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams into the start code splitter: a directed opening with
// leading garbage, sliding and empty start codes and flushes, then random
// well-formed units mixed with noise and broken prefixes, under random
// stalls on both channels. Checking is done by nalsc_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import nalsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_BITS    = 20;
    localparam int DIRECTED_N   = 22;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 16;

    // bit 8 marks the final byte of a buffer
    int dir_list [DIRECTED_N] = '{
        'h0ff, 'h000,                       // garbage ahead of the first start code
        'h000, 'h000, 'h000, 'h001,         // open a unit
        'h065, 'h000, 'h0ff, 'h080,
        'h000, 'h000, 'h000, 'h000, 'h001,  // extra zero in front, still a start code
        'h000, 'h000, 'h000, 'h001,         // empty unit, no marker
        'h01f, 'h1e7,                       // flush with bytes still held
        'h142                               // flush outside any unit
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    in_t  s_data  = '0;
    logic s_ready;
    logic m_valid;
    out_t m_data;

    int err_count;
    int outstanding;
    int bytes_seen;
    int markers_seen;

    int sent_n      = 0;
    int flush_n     = 0;
    bit calm        = 1'b0;
    int hold_req_n  = 0;
    int hold_done_n = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    nal_unit_start_code_splitter #(
        .SIZE_BITS(SIZE_BITS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    nalsc_checker #(
        .SIZE_BITS(SIZE_BITS)
    ) chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .err_count   (err_count),
        .outstanding (outstanding),
        .bytes_seen  (bytes_seen),
        .markers_seen(markers_seen)
    );

    // result side: random stalls, or one long hold-off when the sender asks
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req_n != hold_done_n) begin
                hold_done_n = hold_req_n;
                m_ready     = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready = calm || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // zero-heavy bytes so partial prefixes show up often
    function automatic logic [7:0] stream_fill();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            return 8'h00;
        end else if (pick == 3) begin
            return START_LAST;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 13) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{stream_byte: b, buffer_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_n++;
        if (last) begin
            flush_n++;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        int  pick;
        int  lead;
        int  n;
        int  k;
        int  z;
        bit  cut;
        bit  hold_sent;
        bit  pause_done;
        hold_sent  = 1'b0;
        pause_done = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_list[i]) begin
            send_byte(dir_list[i][7:0], dir_list[i][8]);
        end

        while (sent_n < DIRECTED_N + RANDOM_ITEMS) begin
            calm = (sent_n >= 100 && sent_n < 200);
            if (!hold_sent && sent_n >= 250) begin
                hold_req_n++;
                hold_sent = 1'b1;
            end
            if (!pause_done && sent_n >= 380) begin
                wait_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // start code, sometimes with extra zeros, then a unit body
                lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                n    = $urandom_range(0, 12);
                cut  = ($urandom_range(0, 4) == 0);
                repeat (3 + lead) send_byte(8'h00, 1'b0);
                send_byte(START_LAST, cut && n == 0);
                for (k = 0; k < n; k++) begin
                    send_byte(stream_fill(), cut && k == n - 1);
                end
            end else if (pick < 85) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    send_byte(stream_fill(), $urandom_range(0, 19) == 0);
                end
            end else begin
                // prefix that falls short of a start code
                z = $urandom_range(1, 3);
                repeat (z) send_byte(8'h00, 1'b0);
                send_byte((z < 3) ? START_LAST : 8'($urandom_range(2, 255)),
                          $urandom_range(0, 3) == 0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d stream bytes (%0d directed), %0d flushes, one %0d-cycle hold-off",
                 sent_n, DIRECTED_N, flush_n, HOLD_CYCLES);
        $display("checked %0d payload bytes and %0d end-of-unit markers",
                 bytes_seen, markers_seen);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sim.f
rtl/nalsc_pkg.sv
rtl/nal_unit_start_code_splitter.sv
tb/nalsc_checker.sv
tb/tb_top.sv
